FILE: rtl/core/textured_span_pixel_generator_unit_defines.svh
// assertion macros shared by the span engine modules
`ifndef TEXTURED_SPAN_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define TEXTURED_SPAN_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tsp_pkg.sv
// shared constants, codes and control types of the span engine
package tsp_pkg;

    localparam int MAX_TEX_WIDTH_DEF = 64;
    localparam int MAX_SPAN_DEF      = 64;
    localparam int SHADE_LEVELS      = 32;
    localparam int LEVEL_W           = 5;
    localparam int LEVEL_LSB         = 10;
    localparam int COLOUR_W          = 8;
    localparam int SHADE_AW          = LEVEL_W + COLOUR_W;
    localparam int SHADE_DEPTH       = SHADE_LEVELS * 256;
    localparam int FRAC_W            = 10;
    localparam int LW_W              = 4;
    localparam int SH_W              = 5;

    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int TEXW_W     = 3;

    localparam int MEM_ADDR_W = 13;
    localparam int COORD_W    = 16;
    localparam int LIGHT_W    = 16;
    localparam int COUNT_W    = 7;

    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 1;

    localparam int MEM_ADDR_LSB    = 0;
    localparam int MEM_DATA_LSB    = 13;
    localparam int U_START_LSB     = 21;
    localparam int V_START_LSB     = 37;
    localparam int U_STEP_LSB      = 53;
    localparam int V_STEP_LSB      = 69;
    localparam int LIGHT_START_LSB = 85;
    localparam int LIGHT_STEP_LSB  = 101;
    localparam int COUNT_LSB       = 117;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_TEX   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_SHADE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPAN       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RES_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADING_ENABLE = 2'd2;

    localparam logic [TEXW_W-1:0]   TEX_WIDTH_LOG2_RST = 3'd6;
    localparam logic [COLOUR_W-1:0] TRANSPARENT_MIN    = 8'd254;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_FETCH,
        ST_SHADE,
        ST_EMIT
    } tsp_state_t;

    typedef struct packed {
        logic wr_tex;
        logic wr_shade;
        logic load_span;
        logic step;
        logic emit;
    } tsp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_pixel;
        logic out_free;
    } tsp_status_t;

endpackage

FILE: rtl/core/textured_span_pixel_generator_unit.sv
// top level of the textured span pixel generator
//
// input channel s_*: one item per handshake; s_tuser selects the function
// (load texel, load shade table entry, run span), s_tdata carries address,
// data and the span set-up. output channel m_*: one pixel item per handshake,
// colour in m_tdata, write enable in m_tuser, m_tlast on the final pixel.
// configuration registers are written through cfg_we/cfg_index/cfg_wdata.
// load items are accepted back to back and give no output.
// a span keeps the input closed until its last pixel is loaded: one set-up
// step, then per pixel a texture read, a shade table read and the output
// load; the two registered ram reads lie in series.
// the first pixel item follows the step, fetch, shade and emit states.
// a stalled receiver holds the output register; the engine waits in its
// output state and resumes on the cycle the item is taken.
// reset clears the controller, the output valid flag and the configuration
// to width log2 of 6 and shading off; store contents are not cleared.
module textured_span_pixel_generator_unit #(
    parameter int MAX_TEX_WIDTH = tsp_pkg::MAX_TEX_WIDTH_DEF,
    parameter int MAX_SPAN      = tsp_pkg::MAX_SPAN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mem_addr, mem_data, u_start, v_start, u_step, v_step, light_start,
    // light_step, pixel_count, zero fill
    input  logic [tsp_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [tsp_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_value
    output logic [tsp_pkg::M_TDATA_W-1:0]   m_tdata,
    // write_enable
    output logic [tsp_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import tsp_pkg::*;

    tsp_cmd_t    cmd;
    tsp_status_t status;

    tsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    tsp_datapath #(
        .MAX_TEX_WIDTH (MAX_TEX_WIDTH),
        .MAX_SPAN      (MAX_SPAN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/core/tsp_ram.sv
// generic single write port ram with registered read
module tsp_ram #(
    parameter int WIDTH = tsp_pkg::COLOUR_W,
    parameter int DEPTH = tsp_pkg::SHADE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/tsp_ctrl.sv
// span engine controller state machine
`include "textured_span_pixel_generator_unit_defines.svh"

module tsp_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tsp_pkg::FUNC_W-1:0]  func,
    input  tsp_pkg::tsp_status_t        status,
    output tsp_pkg::tsp_cmd_t           cmd
);

    import tsp_pkg::*;

    tsp_state_t state_reg;
    tsp_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (func)
                        FUNC_LOAD_TEX:   cmd.wr_tex = 1'b1;
                        FUNC_LOAD_SHADE: cmd.wr_shade = 1'b1;
                        FUNC_SPAN: begin
                            cmd.load_span = 1'b1;
                            if (!status.count_zero) begin
                                state_next = ST_STEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_SHADE;
            ST_SHADE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_pixel) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `TSP_ASSERT_NEXT(a_last_pixel_to_idle, aclk, aresetn, cmd.emit && status.last_pixel, state_reg == ST_IDLE, "span did not end after its last item")
    `TSP_ASSERT_NEXT(a_span_starts, aclk, aresetn, cmd.load_span && !status.count_zero, state_reg == ST_STEP, "span with pixels did not start")
    `TSP_ASSERT_NOW(a_load_on_accept, aclk, aresetn, cmd.wr_tex || cmd.wr_shade || cmd.load_span, s_tvalid && s_tready, "store or span load without an accepted item")

endmodule

FILE: rtl/core/tsp_datapath.sv
// span engine datapath: accumulators, texture and shade stores, output register
`include "textured_span_pixel_generator_unit_defines.svh"

module tsp_datapath #(
    parameter int MAX_TEX_WIDTH = tsp_pkg::MAX_TEX_WIDTH_DEF,
    parameter int MAX_SPAN      = tsp_pkg::MAX_SPAN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tsp_pkg::tsp_cmd_t               cmd,
    output tsp_pkg::tsp_status_t            status,
    input  logic                            cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [tsp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [tsp_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    import tsp_pkg::*;

    localparam int TEX_LOG2  = $clog2(MAX_TEX_WIDTH);
    localparam int TEX_AW    = 2 * TEX_LOG2;
    localparam int TEX_DEPTH = MAX_TEX_WIDTH * MAX_TEX_WIDTH;
    localparam int UV_W      = TEX_LOG2 + FRAC_W;
    localparam int CNT_W     = $clog2(MAX_SPAN + 1);

    function automatic logic [UV_W-1:0] fit_uv(input logic [COORD_W-1:0] x);
        logic [UV_W+COORD_W-1:0] wide;
        wide = {{UV_W{1'b0}}, x};
        return wide[UV_W-1:0];
    endfunction

    // item fields
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [COLOUR_W-1:0]   mem_data;
    logic [COORD_W-1:0]    u_start, v_start, u_step, v_step;
    logic [LIGHT_W-1:0]    light_start, light_step;
    logic [COUNT_W-1:0]    pixel_count;

    assign mem_addr    = s_tdata[MEM_ADDR_LSB +: MEM_ADDR_W];
    assign mem_data    = s_tdata[MEM_DATA_LSB +: COLOUR_W];
    assign u_start     = s_tdata[U_START_LSB +: COORD_W];
    assign v_start     = s_tdata[V_START_LSB +: COORD_W];
    assign u_step      = s_tdata[U_STEP_LSB +: COORD_W];
    assign v_step      = s_tdata[V_STEP_LSB +: COORD_W];
    assign light_start = s_tdata[LIGHT_START_LSB +: LIGHT_W];
    assign light_step  = s_tdata[LIGHT_STEP_LSB +: LIGHT_W];
    assign pixel_count = s_tdata[COUNT_LSB +: COUNT_W];

    logic [TEXW_W-1:0]   tex_width_log2_reg, tex_width_log2_next;
    logic                shading_enable_reg, shading_enable_next;
    logic [UV_W-1:0]     u_reg, u_next, v_reg, v_next;
    logic [UV_W-1:0]     du_reg, du_next, dv_reg, dv_next;
    logic [LIGHT_W-1:0]  light_reg, light_next, dl_reg, dl_next;
    logic [CNT_W-1:0]    pixels_left_reg, pixels_left_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [COLOUR_W-1:0] pixel_reg, pixel_next;
    logic                we_reg, we_next;
    logic                last_reg, last_next;

    logic [LW_W-1:0]     lw;
    logic [UV_W-1:0]     uv_mask;
    logic [CNT_W-1:0]    count_sat;
    logic [TEX_AW-1:0]   tex_rd_addr, tex_wr_addr;
    logic [TEX_AW+MEM_ADDR_W-1:0] tex_wr_wide;
    logic [COLOUR_W-1:0] texel, shade_data;
    logic [LIGHT_W-1:0]  light_bias;
    logic [SHADE_AW-1:0] shade_rd_addr;
    logic                opaque;

    // effective width, saturated to the store size
    always_comb begin
        if ({1'b0, tex_width_log2_reg} > LW_W'(TEX_LOG2)) begin
            lw = LW_W'(TEX_LOG2);
        end else begin
            lw = {1'b0, tex_width_log2_reg};
        end
    end

    assign uv_mask = ~({UV_W{1'b1}} << (SH_W'(lw) + SH_W'(FRAC_W)));

    assign count_sat = (pixel_count > COUNT_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN)
                                                         : CNT_W'(pixel_count);

    assign tex_rd_addr = (TEX_AW'(v_reg[UV_W-1:FRAC_W]) << lw)
                       | TEX_AW'(u_reg[UV_W-1:FRAC_W]);
    assign tex_wr_wide = {{TEX_AW{1'b0}}, mem_addr};
    assign tex_wr_addr = tex_wr_wide[TEX_AW-1:0];

    // light / 4 toward zero, level bits taken from the biased value
    assign light_bias    = light_reg + {{(LIGHT_W-2){1'b0}}, light_reg[LIGHT_W-1],
                                        light_reg[LIGHT_W-1]};
    assign shade_rd_addr = {light_bias[LEVEL_LSB +: LEVEL_W], texel};

    tsp_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (TEX_DEPTH)
    ) u_tex_ram (
        .aclk    (aclk),
        .we      (cmd.wr_tex),
        .wr_addr (tex_wr_addr),
        .wr_data (mem_data),
        .rd_addr (tex_rd_addr),
        .rd_data (texel)
    );

    tsp_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (SHADE_DEPTH)
    ) u_shade_ram (
        .aclk    (aclk),
        .we      (cmd.wr_shade),
        .wr_addr (mem_addr[SHADE_AW-1:0]),
        .wr_data (mem_data),
        .rd_addr (shade_rd_addr),
        .rd_data (shade_data)
    );

    assign opaque = texel < TRANSPARENT_MIN;

    always_comb begin
        tex_width_log2_next = tex_width_log2_reg;
        shading_enable_next = shading_enable_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEX_WIDTH_LOG2: tex_width_log2_next = cfg_wdata;
                CFG_SHADING_ENABLE: shading_enable_next = cfg_wdata[0];
                // no effect on item values
                CFG_LOW_RES_MODE: ;
                default: ;
            endcase
        end

        u_next           = u_reg;
        v_next           = v_reg;
        du_next          = du_reg;
        dv_next          = dv_reg;
        light_next       = light_reg;
        dl_next          = dl_reg;
        pixels_left_next = pixels_left_reg;
        if (cmd.load_span) begin
            u_next           = fit_uv(u_start) & uv_mask;
            v_next           = fit_uv(v_start) & uv_mask;
            du_next          = fit_uv(u_step) & uv_mask;
            dv_next          = fit_uv(v_step) & uv_mask;
            light_next       = light_start;
            dl_next          = light_step;
            pixels_left_next = count_sat;
        end else begin
            if (cmd.step) begin
                u_next = (u_reg + du_reg) & uv_mask;
                v_next = (v_reg + dv_reg) & uv_mask;
            end
            if (cmd.emit) begin
                light_next       = light_reg + dl_reg;
                pixels_left_next = pixels_left_reg - CNT_W'(1);
            end
        end

        pixel_next    = pixel_reg;
        we_next       = we_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            we_next       = opaque;
            last_next     = status.last_pixel;
            if (!opaque) begin
                pixel_next = '0;
            end else if (shading_enable_reg) begin
                pixel_next = shade_data;
            end else begin
                pixel_next = texel;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_log2_reg <= TEX_WIDTH_LOG2_RST;
            shading_enable_reg <= 1'b0;
            pixels_left_reg    <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            tex_width_log2_reg <= tex_width_log2_next;
            shading_enable_reg <= shading_enable_next;
            pixels_left_reg    <= pixels_left_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        du_reg    <= du_next;
        dv_reg    <= dv_next;
        light_reg <= light_next;
        dl_reg    <= dl_next;
        pixel_reg <= pixel_next;
        we_reg    <= we_next;
        last_reg  <= last_next;
    end

    assign status.count_zero = (pixel_count == '0);
    assign status.last_pixel = (pixels_left_reg == CNT_W'(1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pixel_reg;
    assign m_tuser  = we_reg;
    assign m_tlast  = last_reg;

    `TSP_ASSERT_NOW(a_emit_has_room, aclk, aresetn, cmd.emit, status.out_free, "item emitted over one not yet taken")
    `TSP_ASSERT_NOW(a_transparent_is_zero, aclk, aresetn, m_tvalid_reg && !we_reg, pixel_reg == '0, "transparent item carries a colour")
    `TSP_ASSERT_NEXT(a_span_loads_count, aclk, aresetn, cmd.load_span && !status.count_zero, pixels_left_reg != '0, "span loaded with no pixels left")

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the textured span pixel generator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsp_pkg::*;

    localparam int          TEX_DEPTH    = MAX_TEX_WIDTH_DEF * MAX_TEX_WIDTH_DEF;
    localparam int          MAX_LW       = $clog2(MAX_TEX_WIDTH_DEF);
    localparam int          FULL_LW      = 3;
    localparam int          TEX_FILL     = 1 << (2 * FULL_LW);
    localparam int          DV_BITS      = 3;
    localparam int          IDLE_PCT     = 13;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                we;
        logic                last;
    } pixel_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // mem_addr, mem_data, u_start, v_start, u_step, v_step, light_start,
    // light_step, pixel_count, zero fill
    logic [S_TDATA_W-1:0]    s_tdata;
    // func
    logic [FUNC_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    // pixel_value
    logic [M_TDATA_W-1:0]    m_tdata;
    // write_enable
    logic [M_TUSER_W-1:0]    m_tuser;
    logic                    m_tlast;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    logic [7:0]              texel_store [TEX_DEPTH];
    logic [7:0]              shade_lut [SHADE_DEPTH];
    logic [TEXW_W-1:0]       tex_log2 = TEX_WIDTH_LOG2_RST;
    logic                    shade_on = 1'b0;
    pixel_t                  expected_pixels [$];
    int                      mismatches  = 0;
    int                      cycle_count = 0;
    int                      hold_len    = 0;
    bit                      idle_enable = 1'b1;

    textured_span_pixel_generator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int unsigned eff_width_log2();
        return (tex_log2 > MAX_LW) ? MAX_LW : tex_log2;
    endfunction

    // opaque texels come from a small set so the shade table fill stays short
    function automatic logic [7:0] opaque_texel(input logic [1:0] sel);
        return {{6{sel[1]}}, 1'b0, sel[0]};
    endfunction

    function automatic logic [7:0] rand_texel();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(254, 255));
        return opaque_texel(2'($urandom));
    endfunction

    // above width 8 not every texture row is filled: keep v low in the first row
    function automatic logic [15:0] fit_v(input logic [15:0] raw);
        int unsigned lw;
        lw = eff_width_log2();
        if (lw <= FULL_LW)
            return raw;
        return raw & ~16'(((1 << (lw + 1)) - 1) << (FRAC_W - 1));
    endfunction

    // small v steps so a full span stays inside the first row
    function automatic logic [15:0] fit_dv(input logic [15:0] raw);
        int unsigned lw;
        lw = eff_width_log2();
        if (lw <= FULL_LW)
            return raw;
        return raw & ~16'(((1 << (lw + FRAC_W - DV_BITS)) - 1) << DV_BITS);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(
        input logic [MEM_ADDR_W-1:0] addr,
        input logic [7:0]            mem_byte,
        input logic [COORD_W-1:0]    u0,
        input logic [COORD_W-1:0]    v0,
        input logic [COORD_W-1:0]    du,
        input logic [COORD_W-1:0]    dv,
        input logic [LIGHT_W-1:0]    l0,
        input logic [LIGHT_W-1:0]    dl,
        input logic [COUNT_W-1:0]    cnt
    );
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[MEM_ADDR_LSB    +: MEM_ADDR_W] = addr;
        word[MEM_DATA_LSB    +: 8]          = mem_byte;
        word[U_START_LSB     +: COORD_W]    = u0;
        word[V_START_LSB     +: COORD_W]    = v0;
        word[U_STEP_LSB      +: COORD_W]    = du;
        word[V_STEP_LSB      +: COORD_W]    = dv;
        word[LIGHT_START_LSB +: LIGHT_W]    = l0;
        word[LIGHT_STEP_LSB  +: LIGHT_W]    = dl;
        word[COUNT_LSB       +: COUNT_W]    = cnt;
        return word;
    endfunction

    // updates the stores and queues the pixels a span will produce
    task automatic predict_pixels(input logic [FUNC_W-1:0] fn,
                                  input logic [S_TDATA_W-1:0] word);
        int unsigned     lw, mmask, rowmask, u, v, du, dv, cnt, taddr;
        logic [15:0]     light, dl;
        logic [7:0]      texel;
        logic [SHADE_AW-1:0] sidx;
        int              level;
        pixel_t          px;
        unique case (fn)
            FUNC_LOAD_TEX: begin
                texel_store[word[MEM_ADDR_LSB +: MEM_ADDR_W] % TEX_DEPTH] =
                    word[MEM_DATA_LSB +: 8];
            end
            FUNC_LOAD_SHADE: begin
                shade_lut[word[MEM_ADDR_LSB +: MEM_ADDR_W] % SHADE_DEPTH] =
                    word[MEM_DATA_LSB +: 8];
            end
            FUNC_SPAN: begin
                lw      = eff_width_log2();
                mmask   = (1024 << lw) - 1;
                rowmask = (1 << lw) * ((1 << lw) - 1);
                u       = word[U_START_LSB +: COORD_W] & mmask;
                v       = word[V_START_LSB +: COORD_W] & mmask;
                du      = word[U_STEP_LSB  +: COORD_W] & mmask;
                dv      = word[V_STEP_LSB  +: COORD_W] & mmask;
                light   = word[LIGHT_START_LSB +: LIGHT_W];
                dl      = word[LIGHT_STEP_LSB  +: LIGHT_W];
                cnt     = word[COUNT_LSB +: COUNT_W];
                if (cnt > MAX_SPAN_DEF)
                    cnt = MAX_SPAN_DEF;
                for (int k = 0; k < cnt; k++) begin
                    u     = (u + du) & mmask;
                    v     = (v + dv) & mmask;
                    taddr = (u >> FRAC_W) + ((v >> (FRAC_W - lw)) & rowmask);
                    texel = texel_store[taddr % TEX_DEPTH];
                    px    = '0;
                    if (texel < TRANSPARENT_MIN) begin
                        px.we = 1'b1;
                        if (shade_on) begin
                            level     = $signed(light);
                            level     = level / 4;
                            sidx      = {level[8 +: LEVEL_W], texel};
                            px.colour = shade_lut[sidx];
                        end else begin
                            px.colour = texel;
                        end
                    end
                    light   = light + dl;
                    px.last = (k == cnt - 1);
                    expected_pixels.push_back(px);
                end
            end
            default: ;
        endcase
    endtask

    // called and returns at a falling edge; valid stays high for the next item
    task automatic send_item(input logic [FUNC_W-1:0] fn,
                             input logic [S_TDATA_W-1:0] word);
        while (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        predict_pixels(fn, word);
        @(negedge aclk);
    endtask

    task automatic send_load(input logic [FUNC_W-1:0] fn,
                             input logic [MEM_ADDR_W-1:0] addr,
                             input logic [7:0] mem_byte);
        send_item(fn, pack_item(addr, mem_byte, 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 7'($urandom)));
    endtask

    task automatic send_span(input logic [15:0] u0, input logic [15:0] v0,
                             input logic [15:0] du, input logic [15:0] dv,
                             input logic [15:0] l0, input logic [15:0] dl,
                             input logic [COUNT_W-1:0] cnt);
        send_item(FUNC_SPAN, pack_item(13'($urandom), 8'($urandom),
                                       u0, v0, du, dv, l0, dl, cnt));
    endtask

    task automatic send_random_span(input int cnt);
        logic [15:0] u0, v0, du, dv;
        int unsigned span_max;
        span_max = (1024 << eff_width_log2()) - 1;
        if ($urandom_range(0, 3) != 0) begin
            u0 = 16'($urandom_range(0, span_max));
            v0 = 16'($urandom_range(0, span_max));
            du = 16'($urandom_range(0, span_max));
            dv = 16'($urandom_range(0, span_max));
        end else begin
            u0 = 16'($urandom);
            v0 = 16'($urandom);
            du = 16'($urandom);
            dv = 16'($urandom);
        end
        send_span(u0, fit_v(v0), du, fit_dv(dv), 16'($urandom), 16'($urandom),
                  7'(cnt));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        unique case (idx)
            CFG_TEX_WIDTH_LOG2: tex_log2 = val[TEXW_W-1:0];
            CFG_LOW_RES_MODE:   ;
            CFG_SHADING_ENABLE: shade_on = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [2:0] lw, input logic lr, input logic sh);
        write_cfg(CFG_TEX_WIDTH_LOG2, lw);
        write_cfg(CFG_LOW_RES_MODE, {2'($urandom), lr});
        write_cfg(CFG_SHADING_ENABLE, {2'($urandom), sh});
    endtask

    task automatic test_fill_stores();
        for (int i = 0; i < TEX_FILL; i++)
            send_load(FUNC_LOAD_TEX, 13'(i + TEX_DEPTH * $urandom_range(0, 1)),
                      rand_texel());
        for (int lvl = 0; lvl < SHADE_LEVELS; lvl++)
            for (int s = 0; s < 4; s++)
                send_load(FUNC_LOAD_SHADE,
                          13'(lvl * 256 + int'(opaque_texel(2'(s)))), 8'($urandom));
    endtask

    task automatic test_directed_spans();
        // out-of-range texel addresses fold onto the store
        send_load(FUNC_LOAD_TEX, 13'h1fff, 8'd254);
        send_load(FUNC_LOAD_TEX, 13'h1001, 8'd255);
        send_load(FUNC_LOAD_SHADE, 13'h1fff, 8'hff);
        send_item(FUNC_UNUSED, pack_item('1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_span(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1);
        send_span(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 7'd64);
        send_span(16'hfc00, 16'hfc00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd2);
        send_span(16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1);
        send_random_span(0);
        send_random_span(127);
        wait_idle();
        write_cfg(CFG_UNUSED_IDX, 3'h7);
        // oversized width with shading, light at both ends of its range
        set_config(3'd7, 1'b1, 1'b1);
        send_span(16'($urandom), fit_v(16'($urandom)), 16'($urandom),
                  fit_dv(16'($urandom)), 16'h8000, 16'h7fff, 7'd8);
        send_span(16'($urandom), fit_v(16'($urandom)), 16'($urandom),
                  fit_dv(16'($urandom)), 16'h7fff, 16'hffff, 7'd8);
        send_span(16'($urandom), fit_v(16'($urandom)), 16'($urandom),
                  fit_dv(16'($urandom)), 16'hfffb, 16'h0000, 7'd4);
        wait_idle();
        set_config(3'd0, 1'b0, 1'b1);
        send_span(16'hffff, 16'hffff, 16'h1234, 16'hffff,
                  16'($urandom), 16'($urandom), 7'd16);
        wait_idle();
        set_config(3'd3, 1'b1, 1'b0);
        send_span(16'hffff, 16'h8000, 16'h0fff, 16'hf123, 16'h0000, 16'h0000, 7'd16);
    endtask

    task automatic test_pressure();
        wait_idle();
        set_config(3'd4, 1'($urandom), 1'b1);
        hold_len = 300;
        repeat (8) send_random_span(16);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_load(FUNC_LOAD_TEX, 13'($urandom), rand_texel());
        else if (pick < 20)
            send_load(FUNC_LOAD_SHADE, 13'($urandom), 8'($urandom));
        else if (pick < 23)
            send_item(FUNC_UNUSED, pack_item(13'($urandom), 8'($urandom), 16'($urandom),
                                             16'($urandom), 16'($urandom), 16'($urandom),
                                             16'($urandom), 16'($urandom), 7'($urandom)));
        else
            send_random_span(($urandom_range(0, 19) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 16));
    endtask

    task automatic test_random_phases();
        logic [2:0] lw;
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            lw = (p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7));
            set_config(lw, 1'($urandom), (p == 2) ? 1'b1 : 1'($urandom));
            // one phase runs with neither side idling
            idle_enable = (p != 3);
            repeat (25) send_random_item();
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                hold_len--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_enable && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{colour: m_tdata, we: m_tuser[0], last: m_tlast};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel item: colour %0d we %0b last %0b",
                             got.colour, got.we, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got.colour !== want.colour || got.we !== want.we ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: colour %0d/%0d we %0b/%0b last %0b/%0b",
                                 want.colour, got.colour, want.we, got.we,
                                 want.last, got.last);
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_LOAD_TEX;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TEX_WIDTH_LOG2;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_fill_stores();
        test_directed_spans();
        test_pressure();
        test_random_phases();
        wait_idle();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
